// ===== rtl/bads_pkg.sv =====
// Package for the 2x2 box-average downscaler: sizes, register indexes,
// shared types and the extent clamp used by the configuration block.
// Depends on nothing; every other file of the block imports it.
package bads_pkg;

  // Sizing of the line store and the counters.
  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int CHANNELS     = 3;
  localparam int CHAN_W       = 8;
  localparam int LANE_W       = CHAN_W + 1;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ADDR_W       = COL_W - 1;
  localparam int HALF_DEPTH   = MAX_WIDTH / 2;
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

  // Configuration port.
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CLAMP_W      = 14;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE  = 2'd2;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Stream packing.
  localparam int PIX_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t [CHANNELS-1:0] lanes_t;
  typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_t;

  // Frame geometry held in the form the counters compare against.
  typedef struct packed {
    logic [COL_W-1:0]  col_last;
    logic [ADDR_W-1:0] pair_last;
    logic [ROW_W-1:0]  row_last;
    logic [ROW_W-2:0]  rowpair_last;
    logic              rgb;
  } cfg_t;

  // One finished 2x2 block on its way to the averaging stage.
  typedef struct packed {
    lanes_t sums;
    lanes_t above;
    logic   row_end;
    logic   frame_end;
  } blk_t;

  // Saturate an extent to the range from two up to the given limit.
  function automatic logic [CLAMP_W-1:0] clamp_extent(input logic [CLAMP_W-1:0] v,
                                                      input logic [CLAMP_W-1:0] limit);
    logic [CLAMP_W-1:0] r;
    r = v;
    if (r < CLAMP_W'(2)) r = CLAMP_W'(2);
    if (r > limit) r = limit;
    return r;
  endfunction

endpackage

// ===== rtl/box_average_downscale_2x2_core.sv =====
// Top level of the 2x2 box-average downscaler.
// Joins the configuration registers, the raster front end and the averaging
// stage. Depends on bads_pkg, bads_cfg, bads_front and bads_out.

// The block takes a raster-order pixel stream, one pixel per beat, and gives
// one output pixel for every 2x2 block: each channel is the floor of the sum
// of its four samples divided by four. It accepts a pixel in every clock
// cycle unless a waiting block holds the input off; the odd-row, odd-column
// pixel that completes a block sends its result through a block register
// (which also holds the half-line store read) and the result register. The
// half-line store holds MAX_WIDTH/2 pair sums of three 9-bit lanes, written
// on even rows and read on odd rows at the same address; it needs no clearing
// after reset. tlast marks the last output pixel of an output row and tuser
// the last of the frame. A trailing odd column or row gives no output. In grey
// mode only the first channel is used and the other two averages are zero.
// Registers: index 0 image width, 1 image height, 2 colour mode (1 rgb); width
// and height are saturated to the supported range when written.
module box_average_downscale_2x2_core (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [bads_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bads_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pixel stream in.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bads_pkg::PIX_DATA_W-1:0] s_axis_tdata,  // chan_a, chan_b, chan_c
  // Downscaled stream out.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bads_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // avg_a, avg_b, avg_c
  output logic                            m_axis_tlast,  // row_end
  output logic                            m_axis_tuser   // frame_end
);
  import bads_pkg::*;

  cfg_t   cfg;
  pixel_t pixel;
  logic   blk_valid;
  logic   blk_ready;
  blk_t   blk;

  // Channel lanes of the incoming beat.
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      pixel[k] = s_axis_tdata[k*CHAN_W +: CHAN_W];
    end
  end

  bads_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bads_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel     (pixel),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  bads_out u_out (
    .clk           (clk),
    .rst           (rst),
    .blk_valid     (blk_valid),
    .blk_ready     (blk_ready),
    .blk           (blk),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTH
  // The last pixel of a frame is always the last of its row.
  a_frame_row_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without row end");

  // A block waiting in the front end means the result register is occupied.
  a_blk_wait: assert property (@(posedge clk) disable iff (rst)
    blk_valid && !blk_ready |-> m_axis_tvalid && !m_axis_tready)
    else $error("block held while the result register was free");
`endif

endmodule

// ===== rtl/bads_cfg.sv =====
// Configuration registers of the 2x2 box-average downscaler.
// Clamps width and height on write and keeps them as last-column and
// last-row values. Depends on bads_pkg.
module bads_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bads_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bads_pkg::CFG_DATA_W-1:0] cfg_data,
  output bads_pkg::cfg_t                  cfg
);
  import bads_pkg::*;

  logic [CLAMP_W-1:0] width_used;
  logic [CLAMP_W-1:0] height_used;

  // Saturated extents of the value on the write port.
  always_comb begin
    width_used  = clamp_extent(CLAMP_W'(cfg_data[WIDTH_REG_W-1:0]), CLAMP_W'(MAX_WIDTH));
    height_used = clamp_extent(CLAMP_W'(cfg_data[HEIGHT_REG_W-1:0]), CLAMP_W'(HEIGHT_LIMIT));
  end

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_last     <= COL_W'(RESET_WIDTH - 1);
      cfg.pair_last    <= ADDR_W'(RESET_WIDTH / 2 - 1);
      cfg.row_last     <= ROW_W'(RESET_HEIGHT - 1);
      cfg.rowpair_last <= (ROW_W - 1)'(RESET_HEIGHT / 2 - 1);
      cfg.rgb          <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          cfg.col_last  <= COL_W'(width_used - CLAMP_W'(1));
          cfg.pair_last <= ADDR_W'((width_used >> 1) - CLAMP_W'(1));
        end
        REG_IMAGE_HEIGHT: begin
          cfg.row_last     <= ROW_W'(height_used - CLAMP_W'(1));
          cfg.rowpair_last <= (ROW_W - 1)'((height_used >> 1) - CLAMP_W'(1));
        end
        REG_COLOUR_MODE: begin
          cfg.rgb <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/bads_front.sv =====
// Raster front end of the 2x2 box-average downscaler: column and row
// counters, horizontal pair sums, the half-line store and the block register.
// Depends on bads_pkg.
module bads_front (
  input  logic                   clk,
  input  logic                   rst,
  input  bads_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bads_pkg::pixel_t       pixel,
  output logic                   blk_valid,
  input  logic                   blk_ready,
  output bads_pkg::blk_t         blk
);
  import bads_pkg::*;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  lanes_t            pair_sum;
  lanes_t            half_line_store [HALF_DEPTH];
  lanes_t            above;
  lanes_t            blk_sums;
  logic              blk_row_end;
  logic              blk_frame_end;

  logic              accept;
  logic              emit;
  logic              store_wr;
  logic [ADDR_W-1:0] addr;
  lanes_t            px;
  lanes_t            sums;
  logic              row_end;
  logic              frame_end;

  // Lane inputs and pair sums; grey mode keeps only the first channel.
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      px[k]   = (cfg.rgb || k == 0) ? {1'b0, pixel[k]} : '0;
      sums[k] = pair_sum[k] + px[k];
    end
  end

  // Position decode of the pixel on the input.
  always_comb begin
    accept    = in_valid && in_ready;
    addr      = column_count[COL_W-1:1];
    emit      = column_count[0] && row_count[0];
    store_wr  = accept && column_count[0] && !row_count[0];
    row_end   = (addr == cfg.pair_last);
    frame_end = row_end && (row_count[ROW_W-1:1] == cfg.rowpair_last);
  end

  // Raster counters; a counter at or past the last position wraps.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count >= cfg.col_last) begin
        column_count <= '0;
        row_count    <= (row_count >= cfg.row_last) ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // The even column of each pair is held until its partner arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sum <= '0;
    end else if (accept && !column_count[0]) begin
      pair_sum <= px;
    end
  end

  // Half-line store: even rows write pair sums, odd rows read them back.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      half_line_store[addr] <= sums;
    end
    if (accept && emit) begin
      above <= half_line_store[addr];
    end
  end

  // Block register between the front end and the averaging stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (accept && emit) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      blk_sums      <= sums;
      blk_row_end   <= row_end;
      blk_frame_end <= frame_end;
    end
  end

  assign in_ready = !blk_valid || blk_ready;
  assign blk      = '{sums: blk_sums, above: above, row_end: blk_row_end,
                      frame_end: blk_frame_end};

`ifndef SYNTH
  // A pixel that completes a block always lands in the block register.
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> blk_valid)
    else $error("completed block did not reach the block register");

  // The input is only held off by a full block register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> blk_valid && !blk_ready)
    else $error("input stalled without a waiting block");

  // The block register is full on the cycle after a stalled block.
  a_blk_hold: assert property (@(posedge clk) disable iff (rst)
    blk_valid && !blk_ready |=> blk_valid)
    else $error("waiting block dropped");
`endif

endmodule

// ===== rtl/bads_out.sv =====
// Averaging and result register of the 2x2 box-average downscaler.
// Adds the stored and current pair sums, divides by four and drives the
// result stream. Depends on bads_pkg.
module bads_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            blk_valid,
  output logic                            blk_ready,
  input  bads_pkg::blk_t                  blk,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bads_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser
);
  import bads_pkg::*;

  logic [OUT_DATA_W-1:0] avg_next;
  logic [LANE_W:0]       total;

  // Floor average of the four samples of each lane.
  always_comb begin
    avg_next = '0;
    total    = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      total = {1'b0, blk.above[k]} + {1'b0, blk.sums[k]};
      avg_next[k*CHAN_W +: CHAN_W] = total[LANE_W:2];
    end
  end

  assign blk_ready = !m_axis_tvalid || m_axis_tready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (blk_ready) begin
      m_axis_tvalid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_valid && blk_ready) begin
      m_axis_tdata <= avg_next;
      m_axis_tlast <= blk.row_end;
      m_axis_tuser <= blk.frame_end;
    end
  end

endmodule

// ===== tb/sv/box_average_downscale_2x2_core_tb.sv =====
// Self-checking testbench for the 2x2 box-average downscaler core.
// Holds a predictor of the averaged pixel stream and the top module that drives the block.
// Depends on bads_pkg and box_average_downscale_2x2_core.
package bads_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  // One downscaled pixel as it leaves the block.
  typedef struct packed {
    logic [7:0] avg_a;
    logic [7:0] avg_b;
    logic [7:0] avg_c;
    logic       row_end;
    logic       frame_end;
  } down_pixel_t;

  // Predicts the averaged stream from the accepted pixels and compares the
  // beats that come out of the block against it.
  class block_average_predictor;
    logic [11:0]  width_reg;
    logic [12:0]  height_reg;
    logic         rgb;
    logic [10:0]  col;
    logic [11:0]  row;
    logic [8:0]   pair [3];
    logic [8:0]   half_line [bads_pkg::HALF_DEPTH][3];
    down_pixel_t  awaited_blocks[$];
    int           errors;
    int           blocks_checked;

    function new();
      width_reg      = 12'(bads_pkg::RESET_WIDTH);
      height_reg     = 13'(bads_pkg::RESET_HEIGHT);
      rgb            = 1'b1;
      col            = '0;
      row            = '0;
      errors         = 0;
      blocks_checked = 0;
      for (int k = 0; k < 3; k++) pair[k] = '0;
    endfunction

    // Register writes, masked to the width of each register.
    function void set_reg(logic [1:0] index, logic [12:0] value);
      case (index)
        bads_pkg::REG_IMAGE_WIDTH:  width_reg = value[11:0];
        bads_pkg::REG_IMAGE_HEIGHT: height_reg = value;
        bads_pkg::REG_COLOUR_MODE:  rgb = value[0];
        default: ;
      endcase
    endfunction

    // Extents as the block uses them, saturated to the supported range.
    function int unsigned span_width();
      int unsigned w;
      w = 32'(width_reg);
      if (w < 2) w = 2;
      if (w > bads_pkg::MAX_WIDTH) w = bads_pkg::MAX_WIDTH;
      return w;
    endfunction

    function int unsigned span_height();
      int unsigned h;
      h = 32'(height_reg);
      if (h < 2) h = 2;
      if (h > bads_pkg::HEIGHT_LIMIT) h = bads_pkg::HEIGHT_LIMIT;
      return h;
    endfunction

    // Advance the raster position by one accepted pixel and queue the
    // averaged block that it completes, if any.
    function void take_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      logic [8:0]  px [3];
      logic [8:0]  sums [3];
      logic [9:0]  total;
      logic [7:0]  avg [3];
      down_pixel_t res;
      w = span_width();
      h = span_height();
      idx = 32'(col >> 1);
      px[0] = {1'b0, a};
      px[1] = rgb ? {1'b0, b} : 9'd0;
      px[2] = rgb ? {1'b0, c} : 9'd0;
      if (!col[0]) begin
        for (int k = 0; k < 3; k++) pair[k] = px[k];
      end else begin
        for (int k = 0; k < 3; k++) sums[k] = pair[k] + px[k];
        if (!row[0]) begin
          for (int k = 0; k < 3; k++) half_line[idx][k] = sums[k];
        end else begin
          for (int k = 0; k < 3; k++) begin
            total = {1'b0, half_line[idx][k]} + {1'b0, sums[k]};
            avg[k] = total[9:2];
          end
          res.avg_a     = avg[0];
          res.avg_b     = avg[1];
          res.avg_c     = avg[2];
          res.row_end   = (idx == w / 2 - 1);
          res.frame_end = res.row_end && ((row >> 1) == h / 2 - 1);
          awaited_blocks.push_back(res);
        end
      end
      // Raster counters wrap at the end of a row and of a frame.
      if (col >= w - 1) begin
        col = '0;
        row = (row >= h - 1) ? 12'd0 : row + 12'd1;
      end else begin
        col = col + 11'd1;
      end
    endfunction

    // Compare one output beat with the oldest prediction.
    function void check_block(down_pixel_t got);
      down_pixel_t want;
      if (awaited_blocks.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t ns: output beat with nothing awaited, got %02h %02h %02h last %b user %b",
                   $time, got.avg_a, got.avg_b, got.avg_c, got.row_end, got.frame_end);
      end else begin
        want = awaited_blocks.pop_front();
        if (want !== got) begin
          errors++;
          if (errors <= 20)
            $display("%0t ns: beat %0d expected %02h %02h %02h last %b user %b, got %02h %02h %02h last %b user %b",
                     $time, blocks_checked, want.avg_a, want.avg_b, want.avg_c, want.row_end,
                     want.frame_end, got.avg_a, got.avg_b, got.avg_c, got.row_end, got.frame_end);
        end
      end
      blocks_checked++;
    endfunction
  endclass

endpackage

module box_average_downscale_2x2_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bads_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PIXELS = 1500;
  localparam int SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [bads_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bads_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [bads_pkg::PIX_DATA_W-1:0] s_axis_tdata = '0;  // chan_a, chan_b, chan_c
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [bads_pkg::OUT_DATA_W-1:0] m_axis_tdata;       // avg_a, avg_b, avg_c
  logic        m_axis_tlast;                           // row_end
  logic        m_axis_tuser;                           // frame_end

  block_average_predictor averager = new();
  logic steady = 1'b0;
  int   cycles = 0;
  int   pixels_sent = 0;
  int   frames_sent = 0;
  int   settings_used = 0;

  always #10 clk = ~clk;

  box_average_downscale_2x2_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // The receiver stalls in about a quarter of the cycles unless in a steady stretch.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Every accepted output beat is checked against the prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      averager.check_block({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                            m_axis_tlast, m_axis_tuser});
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles, %0d beats still awaited",
               $time, cycles, averager.awaited_blocks.size());
      $display("box_average_downscale_2x2_core: mismatch");
      $finish;
    end
  end

  // Offer one pixel, with random gaps in front of it, and wait for the beat.
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    do @(posedge clk); while (!s_axis_tready);
    averager.take_pixel(a, b, c);
    pixels_sent++;
  endtask

  // Whole frames of random pixels at the current extents.
  task automatic send_frames(input int count);
    int unsigned w;
    int unsigned h;
    w = averager.span_width();
    h = averager.span_height();
    for (int f = 0; f < count; f++) begin
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      frames_sent++;
    end
  endtask

  // Stop offering pixels and wait until every awaited beat has come out,
  // then let the pixels that give no output settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (averager.awaited_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    averager.set_reg(index, value);
  endtask

  // A new setting is only written once the block has gone idle.
  task automatic configure(input logic [12:0] width, input logic [12:0] height,
                           input logic [12:0] mode);
    drain();
    write_reg(bads_pkg::REG_IMAGE_WIDTH, width);
    write_reg(bads_pkg::REG_IMAGE_HEIGHT, height);
    write_reg(bads_pkg::REG_COLOUR_MODE, mode);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    int          phase;
    int          random_start;
    logic [12:0] wv;
    logic [12:0] hv;
    logic [7:0]  v;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Colour 5x3 frame: a block of full-scale samples, a block of zeros, then
    // a trailing odd column and a trailing odd row that give no output.
    configure(13'd5, 13'd3, 13'd1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 5; c++) begin
        v = (r == 2) ? 8'hC3 : (c < 2) ? 8'hFF : (c < 4) ? 8'h00 : 8'h5A;
        send_pixel(v, v, v);
      end
    frames_sent++;

    // Grey 3x3 frame, width written with an unused top bit: the average
    // rounds down and the second and third channels are ignored.
    configure(13'h1003, 13'd3, 13'h1FFE);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        v = (r == 1 && c == 1) ? 8'hFE : (r < 2 && c < 2) ? 8'hFF : 8'h81;
        send_pixel(v, 8'hFF, 8'hFF);
      end
    frames_sent++;

    // Random small frames under random settings, including extents below
    // the minimum; one phase runs without any idling.
    random_start = pixels_sent;
    phase = 0;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) == 0) wv = 13'($urandom_range(0, 1));
      else wv = 13'($urandom_range(2, 24));
      wv[12] = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) hv = 13'($urandom_range(0, 1));
      else hv = 13'($urandom_range(2, 10));
      configure(wv, hv, 13'($urandom));
      steady <= (phase == 2);
      send_frames($urandom_range(1, 3));
      steady <= 1'b0;
      phase++;
    end

    // A full 24x10 colour frame with no idling on either side.
    configure(13'd24, 13'd10, 13'd1);
    steady <= 1'b1;
    send_frames(1);
    steady <= 1'b0;

    drain();
    $display("Sent %0d pixels in %0d frames under %0d register settings.",
             pixels_sent, frames_sent, settings_used);
    $display("Checked %0d downscaled beats, %0d errors, %0d beats never seen.",
             averager.blocks_checked, averager.errors, averager.awaited_blocks.size());
    if (averager.errors == 0 && averager.awaited_blocks.size() == 0) begin
      $display("box_average_downscale_2x2_core: match");
    end else begin
      $display("box_average_downscale_2x2_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bads_pkg.sv
rtl/bads_cfg.sv
rtl/bads_front.sv
rtl/bads_out.sv
rtl/box_average_downscale_2x2_core.sv
tb/sv/box_average_downscale_2x2_core_tb.sv
